[sv/sis_pkg.sv]
// Shared types, codes and the generator step of the seeded index shuffle core.
// No dependencies; imported by seeded_index_shuffle_core and sis_mod.
package sis_pkg;

  localparam logic [1:0] MODE_DEFINE  = 2'd0;
  localparam logic [1:0] MODE_SHUFFLE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_DISABLED = 3'd1;
  localparam logic [2:0] STATUS_LOCKED   = 3'd2;
  localparam logic [2:0] STATUS_DONE     = 3'd3;
  localparam logic [2:0] STATUS_TOO_FEW  = 3'd4;

  localparam logic [1:0] REG_SEED   = 2'd0;
  localparam logic [1:0] REG_ENABLE = 2'd1;
  localparam logic [1:0] REG_LOCKED = 2'd2;

  localparam logic [31:0] GOLDEN_MIX = 32'h9e37_79b9;
  localparam int unsigned XS_SHIFT_A = 13;
  localparam int unsigned XS_SHIFT_B = 17;
  localparam int unsigned XS_SHIFT_C = 5;

  localparam int unsigned GEN_W = 32;
  localparam int unsigned ID_W  = 4;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_REPLY    = 10'b00_0000_0010,
    ST_COLLECT  = 10'b00_0000_0100,
    ST_GEN      = 10'b00_0000_1000,
    ST_DIV      = 10'b00_0001_0000,
    ST_RD_J     = 10'b00_0010_0000,
    ST_WR_I     = 10'b00_0100_0000,
    ST_WR_J     = 10'b00_1000_0000,
    ST_OUT_RD   = 10'b01_0000_0000,
    ST_OUT_WAIT = 10'b10_0000_0000
  } sis_state_e;

  typedef struct packed {
    logic            last;
    logic            bad_flag;
    logic [2:0]      status;
    logic [ID_W-1:0] source_id;
    logic [ID_W-1:0] target_id;
  } sis_result_t;

  function automatic logic [GEN_W-1:0] xs_step(input logic [GEN_W-1:0] v);
    logic [GEN_W-1:0] t;
    t = v ^ (v << XS_SHIFT_A);
    t = t ^ (t >> XS_SHIFT_B);
    t = t ^ (t << XS_SHIFT_C);
    return t;
  endfunction

endpackage

[sv/seeded_index_shuffle_core.sv]
// Top level of the seeded index shuffle: location mask, one-time Fisher-Yates shuffle.
// Depends on sis_pkg, sis_ram (permutation and id list) and sis_mod (remainder unit).
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata: mode, location_index
//   m_axis    out  m_axis_tvalid/tready      tdata: target_id, source_id; tuser; tlast
//   apb       in   psel/penable (pready=1)   seed, shuffle_enable, locked
//
// Define and clear items finish in ST_IDLE; refused shuffles reply through ST_REPLY.
// A shuffle of C ids scans the mask at one location per cycle, then does C-1 swaps:
// each swap waits on the bit-serial remainder unit and four permutation RAM accesses,
// and each result takes a RAM read and a load.
// A full result register stalls the sequencer until m_axis_tready frees it.
// Reset clears control state and flags; the RAMs are always written before they are read.
module seeded_index_shuffle_core #(
  parameter int unsigned NUM_LOCATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] mode, [7:2] location_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] target_id, [7:4] source_id
  output logic [3:0]  m_axis_tuser,   // [2:0] status, [3] bad_flag
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sis_pkg::*;

  localparam int unsigned IW = $clog2(NUM_LOCATIONS);
  localparam int unsigned CW = $clog2(NUM_LOCATIONS + 1);
  localparam logic [5:0]  NUM_W = 6'(NUM_LOCATIONS);

  logic [30:0] seed_q;
  logic        enable_q;
  logic        locked_q;

  sis_state_e             state_q, state_d;
  logic [NUM_LOCATIONS-1:0] mask_q, mask_d;
  logic                   shuffled_q, shuffled_d;
  logic                   bad_q, bad_d;
  logic [GEN_W-1:0]       gen_q, gen_d;
  logic [CW-1:0]          count_q, count_d;
  logic [IW-1:0]          ptr_q, ptr_d;
  logic [IW-1:0]          j_q, j_d;
  logic [IW-1:0]          tmp_q, tmp_d;
  logic [2:0]             status_q, status_d;

  logic                   out_valid_q, out_valid_d;
  sis_result_t            out_q, out_d;
  logic                   out_free;

  logic [1:0]             in_mode;
  logic [5:0]             in_loc;
  logic                   in_fire;
  logic                   loc_ok;

  logic                   perm_we, perm_re;
  logic [IW-1:0]          perm_waddr, perm_raddr;
  logic [IW-1:0]          perm_wdata, perm_rdata;
  logic                   ids_we, ids_re;
  logic [IW-1:0]          ids_rdata;

  logic                   mod_start, mod_done;
  logic [CW-1:0]          mod_rem;
  logic [GEN_W-1:0]       gen_next;
  logic [4:0]             tgt_w, src_w;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      enable_q <= 1'b0;
      locked_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_SEED:   seed_q   <= pwdata[30:0];
        REG_ENABLE: enable_q <= pwdata[0];
        REG_LOCKED: locked_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SEED:   prdata = {1'b0, seed_q};
      REG_ENABLE: prdata = {31'd0, enable_q};
      REG_LOCKED: prdata = {31'd0, locked_q};
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  assign in_mode       = s_axis_tdata[1:0];
  assign in_loc        = s_axis_tdata[7:2];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign loc_ok        = !in_loc[5] && ({1'b0, in_loc[4:0]} < NUM_W);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign gen_next      = xs_step(gen_q);
  assign tgt_w         = 5'(ids_rdata);
  assign src_w         = 5'(perm_rdata);

  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    shuffled_d  = shuffled_q;
    bad_d       = bad_q;
    gen_d       = gen_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    j_d         = j_q;
    tmp_d       = tmp_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    perm_we     = 1'b0;
    perm_re     = 1'b0;
    perm_waddr  = count_q[IW-1:0];
    perm_wdata  = ptr_q;
    perm_raddr  = ptr_q;
    ids_we      = 1'b0;
    ids_re      = 1'b0;
    mod_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_DEFINE: begin
              if (!locked_q) begin
                if (!loc_ok || shuffled_q) begin
                  bad_d = 1'b1;
                end else begin
                  mask_d[in_loc[IW-1:0]] = 1'b1;
                end
              end
            end
            MODE_SHUFFLE: begin
              if (locked_q) begin
                status_d = STATUS_LOCKED;
                state_d  = ST_REPLY;
              end else if (!enable_q) begin
                status_d = STATUS_DISABLED;
                state_d  = ST_REPLY;
              end else if (shuffled_q) begin
                status_d = STATUS_DONE;
                state_d  = ST_REPLY;
              end else begin
                count_d = '0;
                ptr_d   = '0;
                state_d = ST_COLLECT;
              end
            end
            MODE_CLEAR: begin
              mask_d     = '0;
              shuffled_d = 1'b0;
              bad_d      = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.target_id = '0;
          out_d.source_id = '0;
          out_d.status    = status_q;
          out_d.bad_flag  = bad_q;
          out_d.last      = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_COLLECT: begin
        if (mask_q[ptr_q]) begin
          perm_we = 1'b1;
          ids_we  = 1'b1;
          count_d = count_q + CW'(1);
        end
        ptr_d = ptr_q + IW'(1);
        if (ptr_q == IW'(NUM_LOCATIONS - 1)) begin
          if (count_d < CW'(2)) begin
            bad_d    = 1'b1;
            status_d = STATUS_TOO_FEW;
            state_d  = ST_REPLY;
          end else begin
            gen_d   = {1'b0, seed_q} ^ GOLDEN_MIX;
            ptr_d   = IW'(count_d - CW'(1));
            state_d = ST_GEN;
          end
        end
      end
      ST_GEN: begin
        gen_d     = gen_next;
        mod_start = 1'b1;
        perm_re   = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (mod_done) begin
          tmp_d   = perm_rdata;
          j_d     = IW'(mod_rem);
          state_d = ST_RD_J;
        end
      end
      ST_RD_J: begin
        perm_re    = 1'b1;
        perm_raddr = j_q;
        state_d    = ST_WR_I;
      end
      ST_WR_I: begin
        perm_we    = 1'b1;
        perm_waddr = ptr_q;
        perm_wdata = perm_rdata;
        state_d    = ST_WR_J;
      end
      ST_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = tmp_q;
        if (ptr_q == IW'(1)) begin
          ptr_d   = '0;
          state_d = ST_OUT_RD;
        end else begin
          ptr_d   = ptr_q - IW'(1);
          state_d = ST_GEN;
        end
      end
      ST_OUT_RD: begin
        perm_re = 1'b1;
        ids_re  = 1'b1;
        state_d = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.target_id = tgt_w[ID_W-1:0];
          out_d.source_id = src_w[ID_W-1:0];
          out_d.status    = STATUS_OK;
          out_d.bad_flag  = bad_q;
          out_d.last      = (CW'(ptr_q) == count_q - CW'(1));
          if (out_d.last) begin
            shuffled_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            ptr_d   = ptr_q + IW'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= '0;
      shuffled_q  <= 1'b0;
      bad_q       <= 1'b0;
      gen_q       <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      shuffled_q  <= shuffled_d;
      bad_q       <= bad_d;
      gen_q       <= gen_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    tmp_q <= tmp_d;
    out_q <= out_d;
  end

  sis_ram #(
    .WIDTH (IW),
    .DEPTH (NUM_LOCATIONS)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (perm_waddr),
    .wdata_i (perm_wdata),
    .re_i    (perm_re),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rdata)
  );

  sis_ram #(
    .WIDTH (IW),
    .DEPTH (NUM_LOCATIONS)
  ) u_ids_ram (
    .clk_i   (clk_i),
    .we_i    (ids_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (ptr_q),
    .re_i    (ids_re),
    .raddr_i (ptr_q),
    .rdata_o (ids_rdata)
  );

  sis_mod #(
    .DIV_W (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (gen_next),
    .divisor_i  (CW'(ptr_q) + CW'(1)),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.source_id, out_q.target_id};
  assign m_axis_tuser  = {out_q.bad_flag, out_q.status};
  assign m_axis_tlast  = out_q.last;

endmodule

[sv/sis_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the permutation and the ascending id list.
module sis_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sis_mod.sv]
// Bit-serial remainder unit: dividend modulo a narrow divisor, one bit a cycle.
// Depends on sis_pkg for the generator width.
module sis_mod #(
  parameter int unsigned DIV_W = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [sis_pkg::GEN_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]         divisor_i,
  output logic                     done_o,
  output logic [DIV_W-1:0]         rem_o
);
  import sis_pkg::*;

  localparam int unsigned CNT_W = $clog2(GEN_W);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [GEN_W-1:0]     dvd_q, dvd_d;
  logic [DIV_W-1:0]     div_q, div_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W:0]       trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[GEN_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = DIV_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = DIV_W'(trial);
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(GEN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Testbench for seeded_index_shuffle_core: directed and random location events
// drive the stream input, and a local predictor checks every shuffle result item.
// Depends on sis_pkg and the core RTL; register writes go through the APB port.
module testbench;
  import sis_pkg::*;

  localparam int unsigned NUM_IDS       = 16;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam logic [30:0] SEED_MAX      = 31'h7FFF_FFFF;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [1:0] mode, [7:2] location_index
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;         // [3:0] target_id, [7:4] source_id
  logic [3:0]  m_axis_tuser;         // [2:0] status, [3] bad_flag
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  logic            rx_ready    = 1'b0;
  logic            hold_req    = 1'b0;
  int unsigned     hold_left   = 0;
  int unsigned     in_gap_max  = 5;
  int unsigned     out_gap_max = 5;
  longint unsigned cycle_count = 0;
  int unsigned     mismatches  = 0;
  int unsigned     items_sent  = 0;

  logic [30:0]        cfg_seed     = '0;
  logic               cfg_enable   = 1'b0;
  logic               cfg_locked   = 1'b0;
  logic [NUM_IDS-1:0] loc_mask     = '0;
  logic               shuffle_done = 1'b0;
  logic               bad_seen     = 1'b0;
  sis_result_t        pending_results[$];

  assign m_axis_tready = rx_ready && (hold_left == 0);

  seeded_index_shuffle_core #(.NUM_LOCATIONS(NUM_IDS)) dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic void push_result(logic [3:0] tgt, logic [3:0] src, logic [2:0] status,
                                      logic last);
    sis_result_t r;
    r.target_id = tgt;
    r.source_id = src;
    r.status    = status;
    r.bad_flag  = bad_seen;
    r.last      = last;
    pending_results.push_back(r);
  endfunction

  function automatic void run_shuffle();
    logic [3:0]  ids [NUM_IDS];
    logic [3:0]  perm [NUM_IDS];
    logic [3:0]  swap;
    logic [31:0] gen;
    logic [31:0] j;
    int          count;
    count = 0;
    for (int k = 0; k < NUM_IDS; k++) begin
      if (loc_mask[k]) begin
        ids[count]  = 4'(k);
        perm[count] = 4'(k);
        count++;
      end
    end
    if (count < 2) begin
      bad_seen = 1'b1;
      push_result(4'd0, 4'd0, STATUS_TOO_FEW, 1'b1);
      return;
    end
    gen = {1'b0, cfg_seed} ^ GOLDEN_MIX;
    for (int i = count - 1; i > 0; i--) begin
      gen = gen ^ (gen << XS_SHIFT_A);
      gen = gen ^ (gen >> XS_SHIFT_B);
      gen = gen ^ (gen << XS_SHIFT_C);
      j = gen % 32'(i + 1);
      swap    = perm[i];
      perm[i] = perm[j];
      perm[j] = swap;
    end
    for (int k = 0; k < count; k++) push_result(ids[k], perm[k], STATUS_OK, k == count - 1);
    shuffle_done = 1'b1;
  endfunction

  function automatic void apply_item(logic [1:0] mode, logic [5:0] loc_bits);
    int idx_val;
    idx_val = $signed(loc_bits);
    case (mode)
      MODE_DEFINE: begin
        if (!cfg_locked) begin
          if (idx_val < 0 || idx_val >= int'(NUM_IDS) || shuffle_done) bad_seen = 1'b1;
          else loc_mask[idx_val] = 1'b1;
        end
      end
      MODE_CLEAR: begin
        loc_mask     = '0;
        shuffle_done = 1'b0;
        bad_seen     = 1'b0;
      end
      MODE_SHUFFLE: begin
        if (cfg_locked) push_result(4'd0, 4'd0, STATUS_LOCKED, 1'b1);
        else if (!cfg_enable) push_result(4'd0, 4'd0, STATUS_DISABLED, 1'b1);
        else if (shuffle_done) push_result(4'd0, 4'd0, STATUS_DONE, 1'b1);
        else run_shuffle();
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [5:0] loc_bits);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {loc_bits, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_item(mode, loc_bits);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] reg_sel, input logic [31:0] value);
    logic [31:0] stored;
    stored = (reg_sel == REG_SEED) ? (value & 32'h7FFF_FFFF) : (value & 32'h1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (reg_sel)
      REG_SEED:   cfg_seed   = stored[30:0];
      REG_ENABLE: cfg_enable = stored[0];
      REG_LOCKED: cfg_locked = stored[0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== stored) note_mismatch("register readback", stored, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [30:0] seed_val, input logic enable,
                            input logic lock);
    settle();
    write_reg(REG_SEED, {1'b0, seed_val});
    write_reg(REG_ENABLE, {31'd0, enable});
    write_reg(REG_LOCKED, {31'd0, lock});
  endtask

  task automatic test_refused_requests();
    set_config(31'd0, 1'b0, 1'b0);
    send_item(MODE_DEFINE, 6'd3);
    send_item(MODE_DEFINE, 6'd9);
    send_item(MODE_SHUFFLE, 6'd0);
    set_config(31'd0, 1'b0, 1'b1);
    send_item(MODE_SHUFFLE, 6'h3F);
    send_item(MODE_DEFINE, 6'd5);
    send_item(MODE_DEFINE, 6'h3F);
    set_config(31'd0, 1'b1, 1'b1);
    send_item(MODE_SHUFFLE, 6'd0);
    send_item(MODE_CLEAR, 6'd0);
  endtask

  task automatic test_too_few_locations();
    set_config(31'd0, 1'b1, 1'b0);
    send_item(MODE_SHUFFLE, 6'd0);
    send_item(MODE_CLEAR, 6'd0);
    send_item(MODE_DEFINE, 6'd15);
    send_item(MODE_SHUFFLE, 6'd0);
  endtask

  task automatic test_index_extremes();
    set_config(SEED_MAX, 1'b1, 1'b0);
    send_item(MODE_CLEAR, 6'h2A);
    send_item(MODE_DEFINE, 6'h20);
    send_item(MODE_DEFINE, 6'h1F);
    send_item(MODE_DEFINE, 6'd16);
    send_item(MODE_UNUSED, 6'h15);
    send_item(MODE_CLEAR, 6'd0);
    send_item(MODE_DEFINE, 6'd0);
    send_item(MODE_DEFINE, 6'd15);
    send_item(MODE_SHUFFLE, 6'd0);
    send_item(MODE_SHUFFLE, 6'd0);
    send_item(MODE_DEFINE, 6'd7);
    send_item(MODE_SHUFFLE, 6'd0);
  endtask

  task automatic test_backpressure();
    set_config(31'($urandom), 1'b1, 1'b0);
    send_item(MODE_CLEAR, 6'($urandom));
    for (int k = 0; k < NUM_IDS; k++) send_item(MODE_DEFINE, 6'(NUM_IDS - 1 - k));
    hold_req <= 1'b1;
    send_item(MODE_SHUFFLE, 6'($urandom));
    send_item(MODE_SHUFFLE, 6'($urandom));
    send_item(MODE_CLEAR, 6'($urandom));
    send_item(MODE_DEFINE, 6'd2);
    send_item(MODE_DEFINE, 6'd11);
    send_item(MODE_SHUFFLE, 6'($urandom));
  endtask

  task automatic test_random_sessions();
    int unsigned start;
    int unsigned want_ids;
    int unsigned base;
    int unsigned roll;
    logic [30:0] seed_val;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 7);
      seed_val = (roll == 0) ? 31'd0 : (roll == 1) ? SEED_MAX : 31'($urandom);
      set_config(seed_val, $urandom_range(0, 7) != 0, $urandom_range(0, 9) == 0);
      in_gap_max  = ($urandom_range(0, 4) == 0) ? 0 : 5;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      send_item(MODE_CLEAR, 6'($urandom));
      want_ids = ($urandom_range(0, 5) == 0) ? NUM_IDS : $urandom_range(0, NUM_IDS);
      base = $urandom_range(0, NUM_IDS - 1);
      for (int k = 0; k < want_ids; k++) begin
        if (want_ids == NUM_IDS) send_item(MODE_DEFINE, 6'((base + k) % NUM_IDS));
        else send_item(MODE_DEFINE, 6'($urandom_range(0, NUM_IDS - 1)));
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item($urandom_range(0, 1) ? MODE_UNUSED : MODE_DEFINE, 6'($urandom));
      end
      send_item(MODE_SHUFFLE, 6'($urandom));
      if ($urandom_range(0, 3) == 0) send_item(MODE_SHUFFLE, 6'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        send_item(MODE_DEFINE, 6'($urandom_range(0, NUM_IDS - 1)));
        send_item(MODE_SHUFFLE, 6'($urandom));
      end
    end
    in_gap_max  = 5;
    out_gap_max = 5;
  endtask

  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap != 0) begin
        rx_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rx_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    sis_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected item, target_id", 0, m_axis_tdata[3:0]);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[3:0] !== want.target_id)
          note_mismatch("target_id", want.target_id, m_axis_tdata[3:0]);
        if (m_axis_tdata[7:4] !== want.source_id)
          note_mismatch("source_id", want.source_id, m_axis_tdata[7:4]);
        if (m_axis_tuser[2:0] !== want.status)
          note_mismatch("status", want.status, m_axis_tuser[2:0]);
        if (m_axis_tuser[3] !== want.bad_flag)
          note_mismatch("bad_flag", want.bad_flag, m_axis_tuser[3]);
        if (m_axis_tlast !== want.last)
          note_mismatch("last", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_refused_requests();
    test_too_few_locations();
    test_index_extremes();
    test_backpressure();
    test_random_sessions();
    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
